// ===== hdl/bd4x4_pkg.sv =====
// Shared types, constants and lane arithmetic for the 4x4 box downscaler.
package bd4x4_pkg;

  localparam int PIX_W       = 32;
  localparam int BIG_CNT_W   = 12;
  localparam int SMALL_IDX_W = 10;
  localparam int LANE_W      = 12;
  localparam int LANES       = 3;
  localparam int SUM_W       = LANES * LANE_W;
  localparam int COLS        = 1 << SMALL_IDX_W;
  localparam int BIG_W_W     = 13;
  localparam int SMALL_W_W   = 11;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BIG_CNT_W-1:0] BIG_CNT_MAX = '1;

  // position of a big pixel inside its 4-wide block
  localparam logic [1:0] CX_FIRST = 2'd0;
  localparam logic [1:0] CX_READ  = 2'd2;
  localparam logic [1:0] CX_LAST  = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIG_WIDTH    = 2'd0,
    CFG_SMALL_WIDTH  = 2'd1,
    CFG_SMALL_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [BIG_W_W-1:0]   big_width;
    logic [SMALL_W_W-1:0] small_width;
    logic [SMALL_W_W-1:0] small_height;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic [PIX_W-1:0]       pixel;
    logic [SMALL_IDX_W-1:0] column;
    logic [SMALL_IDX_W-1:0] row;
    logic                   last;
  } res_t;

  function automatic logic [SUM_W-1:0] lanes_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      r[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W] + b[k*LANE_W +: LANE_W];
    end
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] spread_pixel(input logic [PIX_W-1:0] p);
    return {4'h0, p[23:16], 4'h0, p[15:8], 4'h0, p[7:0]};
  endfunction

  // sum of 16 pixels per lane, divided by 16
  function automatic logic [PIX_W-1:0] average_of(input logic [SUM_W-1:0] s);
    return {8'h00, s[35:28], s[23:16], s[11:4]};
  endfunction

endpackage

// ===== hdl/bd4x4_in_if.sv =====
// Big-pixel input channel.
interface bd4x4_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  logic        start_of_image;

  modport source (output valid, output pixel_in, output start_of_image, input ready);
  modport sink   (input valid, input pixel_in, input start_of_image, output ready);
endinterface

// ===== hdl/bd4x4_out_if.sv =====
// Small-pixel result channel.
interface bd4x4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [9:0]  out_column;
  logic [9:0]  out_row;
  logic        last_of_image;

  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output last_of_image, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input last_of_image, output ready);
endinterface

// ===== hdl/bd4x4_core.sv =====
// Position counters, row and column sums, corner hold and result selection.
module bd4x4_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [bd4x4_pkg::PIX_W-1:0]    pixel,
  input  logic                           sof,
  input  bd4x4_pkg::cfg_t                cfg,
  output bd4x4_pkg::res_t                res
);

  logic [bd4x4_pkg::BIG_CNT_W-1:0]   big_column_r, big_column_nxt;
  logic [bd4x4_pkg::BIG_CNT_W-1:0]   big_row_r, big_row_nxt;
  logic [bd4x4_pkg::SUM_W-1:0]       row_sum_r, row_sum_nxt;
  logic [bd4x4_pkg::PIX_W-1:0]       corner_r, corner_nxt;
  logic [bd4x4_pkg::SUM_W-1:0]       col_rd_r;
  logic [bd4x4_pkg::SUM_W-1:0]       col_sums [bd4x4_pkg::COLS];

  logic [bd4x4_pkg::BIG_CNT_W-1:0]   col, row;
  logic [1:0]                        cx, ry;
  logic [bd4x4_pkg::SMALL_IDX_W-1:0] bx, by;
  logic [bd4x4_pkg::SMALL_W_W-1:0]   bx1, by1, bx_w;
  logic [bd4x4_pkg::BIG_W_W-1:0]     col_plus;
  logic [bd4x4_pkg::SUM_W-1:0]       total;
  logic                              row_end;
  logic                              not_last_row, last_row, last_col, col_in;

  always_comb begin
    col      = sof ? '0 : big_column_r;
    row      = sof ? '0 : big_row_r;
    cx       = col[1:0];
    ry       = row[1:0];
    bx       = col[bd4x4_pkg::BIG_CNT_W-1:2];
    by       = row[bd4x4_pkg::BIG_CNT_W-1:2];
    bx_w     = {1'b0, bx};
    bx1      = bx_w + 11'd1;
    by1      = {1'b0, by} + 11'd1;
    col_plus = {1'b0, col} + 13'd1;
    row_end  = (col_plus >= cfg.big_width) || (col == bd4x4_pkg::BIG_CNT_MAX);

    not_last_row = by1 < cfg.small_height;
    last_row     = by1 == cfg.small_height;
    last_col     = bx1 == cfg.small_width;
    col_in       = bx_w < cfg.small_width;

    if (cx == bd4x4_pkg::CX_FIRST) begin
      row_sum_nxt = bd4x4_pkg::spread_pixel(pixel);
    end else begin
      row_sum_nxt = bd4x4_pkg::lanes_add(row_sum_r, bd4x4_pkg::spread_pixel(pixel));
    end
    // first row of a block starts the column sum fresh
    total = (ry != 2'd0) ? bd4x4_pkg::lanes_add(col_rd_r, row_sum_nxt) : row_sum_nxt;

    if (row_end) begin
      big_column_nxt = '0;
      big_row_nxt    = (row != bd4x4_pkg::BIG_CNT_MAX) ? row + 12'd1 : row;
    end else begin
      big_column_nxt = col + 12'd1;
      big_row_nxt    = row;
    end

    corner_nxt = corner_r;
    res        = '0;
    res.column = bx;
    res.row    = by;
    if (cx == bd4x4_pkg::CX_LAST) begin
      if (ry == 2'd3 && not_last_row && (bx1 < cfg.small_width)) begin
        res.valid = 1'b1;
        res.pixel = bd4x4_pkg::average_of(total);
      end
    end else if (cx == bd4x4_pkg::CX_FIRST && col_in) begin
      if (not_last_row && last_col) begin
        if (ry == 2'd0) begin
          corner_nxt = pixel;
        end else if (ry == 2'd3) begin
          res.valid = 1'b1;
          res.pixel = corner_r;
        end
      end else if (last_row && ry == 2'd0) begin
        res.valid = 1'b1;
        res.pixel = pixel;
        res.last  = last_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_column_r <= '0;
      big_row_r    <= '0;
      row_sum_r    <= '0;
      corner_r     <= '0;
    end else if (go) begin
      big_column_r <= big_column_nxt;
      big_row_r    <= big_row_nxt;
      row_sum_r    <= row_sum_nxt;
      corner_r     <= corner_nxt;
    end
  end

  // read on the third pixel of a block, write back on the fourth
  always_ff @(posedge clk) begin
    if (go && cx == bd4x4_pkg::CX_READ) begin
      col_rd_r <= col_sums[bx];
    end
  end

  always_ff @(posedge clk) begin
    if (go && cx == bd4x4_pkg::CX_LAST) begin
      col_sums[bx] <= total;
    end
  end

endmodule

// ===== hdl/box_downscale_4x4_top.sv =====
// Top level of the 4x4 box downscaler: handshakes, configuration and stage registers.
//
// Accepts one big pixel per clock while the result channel is not stalled; either channel may stall at will.
// A pixel passes an input register and then one stage of logic into the result
// register. The result register loads from the input register only while it is empty
// or its result is being taken, so a stalled result holds the pixel. Per-column sums live in a
// 1024 x 36 memory with one port:
// each 4-pixel block reads its column entry on its third pixel and writes it
// back on its fourth, so the memory never limits the rate. Configuration may
// only be written while the block is idle; it needs no clearing pass after reset.
module box_downscale_4x4_top (
  input  logic                               clk,
  input  logic                               rst_n,
  bd4x4_in_if.sink                           in_px,
  bd4x4_out_if.source                        out_px,
  input  logic                               cfg_we,
  input  logic [bd4x4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bd4x4_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bd4x4_pkg::cfg_t             cfg_r;
  logic                        a_valid_r;
  logic [bd4x4_pkg::PIX_W-1:0] a_pixel_r;
  logic                        a_sof_r;
  bd4x4_pkg::res_t             res;
  bd4x4_pkg::res_t             out_r;
  logic                        proc_go;
  logic                        in_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.big_width    <= 13'd2513;
      cfg_r.small_width  <= 11'd628;
      cfg_r.small_height <= 11'd200;
    end else if (cfg_we) begin
      unique case (bd4x4_pkg::cfg_reg_t'(cfg_index))
        bd4x4_pkg::CFG_BIG_WIDTH:    cfg_r.big_width    <= cfg_data;
        bd4x4_pkg::CFG_SMALL_WIDTH:  cfg_r.small_width  <= cfg_data[10:0];
        bd4x4_pkg::CFG_SMALL_HEIGHT: cfg_r.small_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign proc_go     = a_valid_r && (!out_r.valid || out_px.ready);
  assign in_px.ready = !a_valid_r || proc_go;
  assign in_xfer     = in_px.valid && in_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_px.ready) begin
      a_valid_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_pixel_r <= in_px.pixel_in;
      a_sof_r   <= in_px.start_of_image;
    end
  end

  bd4x4_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (proc_go),
    .pixel (a_pixel_r),
    .sof   (a_sof_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (proc_go) begin
      out_r.valid <= res.valid;
    end else if (out_px.ready) begin
      out_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res.valid) begin
      out_r.pixel  <= res.pixel;
      out_r.column <= res.column;
      out_r.row    <= res.row;
      out_r.last   <= res.last;
    end
  end

  assign out_px.valid         = out_r.valid;
  assign out_px.pixel_out     = out_r.pixel;
  assign out_px.out_column    = out_r.column;
  assign out_px.out_row       = out_r.row;
  assign out_px.last_of_image = out_r.last;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> in_px.ready)
    else $error("input stage empty but not ready");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_r.valid && !out_px.ready) |-> !proc_go)
    else $error("pixel processed while result stalled");

  a_xfer_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> a_valid_r)
    else $error("transferred pixel lost from input stage");

endmodule
